@@ rtl/mmfs_pkg.sv @@
// mmfs_pkg: shared constants, codes and controller/datapath interface types
// for the min-max feature scaler; no dependencies
`timescale 1ns / 1ps

package mmfs_pkg;

  // column count and field widths
  localparam int COLUMNS       = 64;
  localparam int COL_BITS      = 6;
  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int SCALED_BITS   = FRACTION_BITS + 1;

  // restoring divider: one integer step plus one step per fraction bit
  localparam int DIV_STEPS = FRACTION_BITS + 1;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  // stream packing
  localparam int IN_DATA_BITS   = COL_BITS + VALUE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_BITS  = 2;
  localparam int OUT_DATA_BITS  = COL_BITS + SCALED_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_BITS = 2;

  // item kinds
  localparam logic KIND_FIT       = 1'b0;
  localparam logic KIND_TRANSFORM = 1'b1;

  // 1.0 in the scaled format
  localparam logic [SCALED_BITS-1:0] ONE_SCALED = SCALED_BITS'(1) << FRACTION_BITS;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic rd;          // read the column bounds
    logic calc;        // update bounds or classify and set up the divide
    logic step;        // one divider iteration
    logic step_first;  // integer step, no shift
    logic out_load;    // move the result into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic kind;      // kind of the held item
    logic need_div;  // in-range transform, divider required
    logic out_busy;  // output register holds a result not taken this cycle
  } sts_t;

endpackage

@@ rtl/min_max_feature_scaler.sv @@
// min_max_feature_scaler: top level, joins the controller and the datapath
// depends on mmfs_pkg, mmfs_ctrl, mmfs_dp
`timescale 1ns / 1ps

// per-column min-max scaler over 64 feature columns
// input channel (in_*): one transfer carries a sample for one column;
//   in_tuser[0] selects fit (0) or transform (1), in_tuser[1] restarts
//   the column bounds on a fit
// a fit transfer widens the column's stored min and max and gives no result
// a transform transfer gives one result on the out_* channel:
//   (sample - min) / (max - min) with 16 fraction bits, saturated to [0, 1.0],
//   with clipped and degenerate flags in out_tuser
// one item is in work at a time; in_tready is high only between items
// a fit passes the bounds read and the update; a transform passes the bounds read,
//   classification and result hand-off, an in-range one also the shared
//   restoring divider, one quotient bit per cycle
// the result sits in an output register, so the next item is taken while it
//   waits; a receiver stall holds the block only once a second result is ready
// reset (rst_n low, synchronous) marks every column's bounds as zero and
//   empties the output register; no clearing pass is needed

module min_max_feature_scaler (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mmfs_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // column[5:0], sample_value[37:6], zero pad
  input  logic [mmfs_pkg::IN_TUSER_BITS-1:0]  in_tuser,   // kind[0], first_of_column[1]
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mmfs_pkg::OUT_TDATA_BITS-1:0] out_tdata,  // result_column[5:0], scaled[22:6], zero pad
  output logic [mmfs_pkg::OUT_TUSER_BITS-1:0] out_tuser   // clipped[0], degenerate[1]
);

  // command and status between sequencer and datapath
  mmfs_pkg::cmd_t cmd;
  mmfs_pkg::sts_t sts;

  // sequencer: idle, bounds read, classify/update, divide, result hand-off
  mmfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bounds memories, divider and output register
  mmfs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/mmfs_ctrl.sv @@
// mmfs_ctrl: sequencing state machine of the min-max feature scaler
// depends on mmfs_pkg
`timescale 1ns / 1ps

module mmfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mmfs_pkg::sts_t sts,
  output mmfs_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DIV,
    S_OUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [mmfs_pkg::STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                           rdy_r;

  assign in_tready = rdy_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        cnt_nxt  = '0;
        if (sts.kind == mmfs_pkg::KIND_FIT) begin
          state_nxt = S_IDLE;
        end else if (sts.need_div) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        cmd.step       = 1'b1;
        cmd.step_first = (cnt_r == '0);
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == mmfs_pkg::STEP_BITS'(mmfs_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdy_r   <= (state_nxt == S_IDLE);
    end
  end

endmodule

@@ rtl/mmfs_dp.sv @@
// mmfs_dp: bounds memories, classification, restoring divider and output register
// depends on mmfs_pkg
`timescale 1ns / 1ps

module mmfs_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mmfs_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  input  logic [mmfs_pkg::IN_TUSER_BITS-1:0]   in_tuser,
  input  logic                                 out_tready,
  input  mmfs_pkg::cmd_t                       cmd,
  output mmfs_pkg::sts_t                       sts,
  output logic                                 out_tvalid,
  output logic [mmfs_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic [mmfs_pkg::OUT_TUSER_BITS-1:0]  out_tuser
);

  localparam int VB = mmfs_pkg::VALUE_BITS;
  localparam int SB = mmfs_pkg::SCALED_BITS;

  // held item
  logic                          kind_r;
  logic                          first_r;
  logic [mmfs_pkg::COL_BITS-1:0] col_r;
  logic signed [VB-1:0]          val_r;

  // bounds storage, entries read as zero until first written
  logic signed [VB-1:0]          lo_mem [mmfs_pkg::COLUMNS];
  logic signed [VB-1:0]          hi_mem [mmfs_pkg::COLUMNS];
  logic [mmfs_pkg::COLUMNS-1:0]  vld_r;
  logic signed [VB-1:0]          lo_q_r, hi_q_r;
  logic                          vld_q_r;

  logic signed [VB-1:0] lo_cur, hi_cur, lo_new, hi_new;
  logic                 degen, below, above, wr_en;
  logic [VB-1:0]        num_w, den_w;

  // divider
  logic [VB:0]   rem_r;
  logic [VB-1:0] den_r;
  logic [SB-1:0] q_r;
  logic          clip_r, degen_r;
  logic [VB:0]   trial;
  logic [VB+1:0] diff;
  logic          take;

  // output register
  logic                          out_valid_r;
  logic [mmfs_pkg::COL_BITS-1:0] out_col_r;
  logic [SB-1:0]                 out_scaled_r;
  logic                          out_clip_r, out_degen_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_tuser[0];
      first_r <= in_tuser[1];
      col_r   <= in_tdata[mmfs_pkg::COL_BITS-1:0];
      val_r   <= in_tdata[mmfs_pkg::COL_BITS +: VB];
    end
  end

  // bounds read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      lo_q_r  <= lo_mem[col_r];
      hi_q_r  <= hi_mem[col_r];
      vld_q_r <= vld_r[col_r];
    end
  end

  assign lo_cur = vld_q_r ? lo_q_r : '0;
  assign hi_cur = vld_q_r ? hi_q_r : '0;

  // fit update
  assign lo_new = (first_r || (val_r < lo_cur)) ? val_r : lo_cur;
  assign hi_new = (first_r || (val_r > hi_cur)) ? val_r : hi_cur;
  assign wr_en  = cmd.calc && (kind_r == mmfs_pkg::KIND_FIT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[col_r] <= lo_new;
      hi_mem[col_r] <= hi_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[col_r] <= 1'b1;
    end
  end

  // transform classification; on the divide path both differences lie in
  // [0, 2^VB - 1], so the wrapped difference is the unsigned value
  assign degen = (hi_cur <= lo_cur);
  assign below = (val_r < lo_cur);
  assign above = (val_r > hi_cur);
  assign num_w = val_r - lo_cur;
  assign den_w = hi_cur - lo_cur;

  assign sts.kind     = kind_r;
  assign sts.need_div = !degen && !below && !above;
  assign sts.out_busy = out_valid_r && !out_tready;

  // restoring step: the first step compares without shifting
  assign trial = cmd.step_first ? rem_r : {rem_r[VB-1:0], 1'b0};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign take  = !diff[VB+1];

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rem_r   <= {1'b0, num_w};
      den_r   <= den_w;
      q_r     <= (!degen && !below && above) ? mmfs_pkg::ONE_SCALED : '0;
      clip_r  <= !degen && (below || above);
      degen_r <= degen;
    end else if (cmd.step) begin
      rem_r <= take ? diff[VB:0] : trial;
      q_r   <= {q_r[SB-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col_r    <= col_r;
      out_scaled_r <= q_r;
      out_clip_r   <= clip_r;
      out_degen_r  <= degen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mmfs_pkg::OUT_TDATA_BITS'({out_scaled_r, out_col_r});
  assign out_tuser  = {out_degen_r, out_clip_r};

endmodule
